FILE: sv/hsv2rgb_pkg.sv
// Package with the shared constants and types of the HSV to RGB converter.
package hsv2rgb_pkg;

   localparam int HueWidth  = 10;
   localparam int ChanWidth = 8;
   localparam int QFrac     = 16;
   // Unit-range quantities reach exactly 1.0, so they need one integer bit.
   localparam int QWidth    = QFrac + 1;
   // Hue divided by 60 degrees, in Q16; stays below 6.0.
   localparam int TWidth    = QFrac + 3;

   localparam int unsigned QOne      = 65536;
   localparam int unsigned DegFull   = 360;
   localparam int unsigned ChanMax   = 255;
   localparam int unsigned ByteOfMax = 255;

   // Degrees: t = hd*65536/60 = 1092*hd + floor(4*hd/15).
   // The remainder term uses a reciprocal of 15 with a 16-bit shift.
   localparam int unsigned DegWhole     = 1092;
   localparam int unsigned DegFracMul   = 4 * 4370;
   localparam int          DegFracShift = 16;

   // Byte scale: t = b*393216/255 = 1542*b + floor(6*b/255).
   // The remainder term uses a reciprocal of 255 with a 22-bit shift.
   localparam int unsigned ByteWhole     = 1542;
   localparam int unsigned ByteFracMul   = 6 * 16449;
   localparam int          ByteFracShift = 22;

   // 60-degree sectors of the color wheel.
   typedef enum logic [2:0] {
      SEC_RED_YELLOW,
      SEC_YELLOW_GREEN,
      SEC_GREEN_CYAN,
      SEC_CYAN_BLUE,
      SEC_BLUE_MAGENTA,
      SEC_MAGENTA_RED
   } sector_type;

endpackage

FILE: sv/hsv2rgb_ifs.sv
// Valid/ready channel interfaces for the HSV request and RGB response.
interface hsv2rgb_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [hsv2rgb_pkg::HueWidth-1:0]      hue;
   logic                                  hue_is_byte;
   logic [hsv2rgb_pkg::ChanWidth-1:0]     saturation;
   logic [hsv2rgb_pkg::ChanWidth-1:0]     value;

   modport source (output valid, hue, hue_is_byte, saturation, value, input ready);
   modport sink   (input valid, hue, hue_is_byte, saturation, value, output ready);
endinterface

interface hsv2rgb_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [hsv2rgb_pkg::ChanWidth-1:0]     red;
   logic [hsv2rgb_pkg::ChanWidth-1:0]     green;
   logic [hsv2rgb_pkg::ChanWidth-1:0]     blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

FILE: sv/hsv_to_rgb_converter_top.sv
// HSV to RGB converter: four-stage pipeline, one transaction per clock while responses are taken.
//
// Usage:
//   req_chan carries hue (degrees, reduced modulo 360, or a 0..255 scale when
//   hue_is_byte is set), saturation and value. rsp_chan returns the 8-bit red,
//   green and blue result, one response for every request, in order.
//   The pipeline has four register stages: hue scaling and unit conversion,
//   chroma multiply, secondary-component multiply, channel select and scale.
//   Each request passes through stages 1 to 4 in order before its response is valid,
//   and a new request is accepted every cycle while responses are taken.
//   The throughput of one transaction per clock while responses are taken is set by the
//   stage registers; the chroma and secondary multipliers sit in stages 2 and 3.
//   When rsp_chan stalls, each stage holds its contents and takes new data
//   only where the stage after it has room, so req_chan.ready drops only
//   once all four stages are full. Nothing is dropped or repeated.
//   Synchronous reset clears all stage valid bits; the pipeline is empty and
//   ready for a request on the first cycle after reset.
module hsv_to_rgb_converter_top (
   input  logic                 clock,
   input  logic                 reset,
   hsv2rgb_req_if.sink          req_chan,
   hsv2rgb_rsp_if.source        rsp_chan
);

   localparam int QW = hsv2rgb_pkg::QWidth;
   localparam int TW = hsv2rgb_pkg::TWidth;
   localparam int CW = hsv2rgb_pkg::ChanWidth;

   // Scales a 0..255 input to the Q16 unit range: x*65536/255 = 257*x + (x==255).
   function automatic logic [QW-1:0] to_unit(input logic [CW-1:0] raw);
      logic [QW-1:0] base;
      base = QW'(raw) * QW'(257);
      return base + QW'(raw == CW'(hsv2rgb_pkg::ByteOfMax));
   endfunction

   // Scales a Q16 unit value by 255, truncates and limits to 255.
   function automatic logic [CW-1:0] to_chan(input logic [QW-1:0] q);
      logic [QW+CW-1:0] prod;
      prod = {q, CW'(0)} - (QW + CW)'(q);
      if (prod[QW+CW-1:hsv2rgb_pkg::QFrac]
          > (QW + CW - hsv2rgb_pkg::QFrac)'(hsv2rgb_pkg::ChanMax))
         return CW'(hsv2rgb_pkg::ChanMax);
      return prod[hsv2rgb_pkg::QFrac+CW-1:hsv2rgb_pkg::QFrac];
   endfunction

   function automatic logic [hsv2rgb_pkg::HueWidth-1:0] HueWidthCast(input int unsigned n);
      return hsv2rgb_pkg::HueWidth'(n);
   endfunction

   // Stage handshake.
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic valid1_in, valid2_in, valid3_in, valid4_in;
   logic load1, load2, load3, load4;

   assign load4 = !valid4_ff || rsp_chan.ready;
   assign load3 = !valid3_ff || load4;
   assign load2 = !valid2_ff || load3;
   assign load1 = !valid1_ff || load2;

   assign req_chan.ready = load1;

   assign valid1_in = load1 ? req_chan.valid : valid1_ff;
   assign valid2_in = load2 ? valid1_ff : valid2_ff;
   assign valid3_in = load3 ? valid2_ff : valid3_ff;
   assign valid4_in = load4 ? valid3_ff : valid4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
         valid4_ff <= valid4_in;
      end
   end

   // Stage 1: hue over 60 degrees in Q16, saturation and value in Q16.
   logic [8:0]                   deg_mod;
   logic [23:0]                  deg_frac_prod;
   logic [TW-1:0]                t_deg;
   logic [7:0]                   hue_byte;
   logic [25:0]                  byte_frac_prod;
   logic [TW-1:0]                t_byte;
   logic [TW-1:0]                t_in;
   logic [TW-1:0]                t_ff;
   logic [QW-1:0]                sat_q_in, sat_q_ff;
   logic [QW-1:0]                val_q_in, val_q_ff;

   always_comb begin
      if (req_chan.hue >= HueWidthCast(2 * hsv2rgb_pkg::DegFull))
         deg_mod = 9'(req_chan.hue - HueWidthCast(2 * hsv2rgb_pkg::DegFull));
      else if (req_chan.hue >= HueWidthCast(hsv2rgb_pkg::DegFull))
         deg_mod = 9'(req_chan.hue - HueWidthCast(hsv2rgb_pkg::DegFull));
      else
         deg_mod = req_chan.hue[8:0];

      deg_frac_prod = 24'(deg_mod) * 24'(hsv2rgb_pkg::DegFracMul);
      t_deg = TW'(deg_mod) * TW'(hsv2rgb_pkg::DegWhole)
            + TW'(deg_frac_prod[23:hsv2rgb_pkg::DegFracShift]);

      hue_byte = req_chan.hue[7:0];
      byte_frac_prod = 26'(hue_byte) * 26'(hsv2rgb_pkg::ByteFracMul);
      // The top of the byte scale lands on 360 degrees, which wraps to zero.
      if (hue_byte == 8'(hsv2rgb_pkg::ByteOfMax))
         t_byte = '0;
      else
         t_byte = TW'(hue_byte) * TW'(hsv2rgb_pkg::ByteWhole)
                + TW'(byte_frac_prod[25:hsv2rgb_pkg::ByteFracShift]);

      t_in     = req_chan.hue_is_byte ? t_byte : t_deg;
      sat_q_in = to_unit(req_chan.saturation);
      val_q_in = to_unit(req_chan.value);
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         t_ff     <= t_in;
         sat_q_ff <= sat_q_in;
         val_q_ff <= val_q_in;
      end
   end

   // Stage 2: chroma and the sawtooth weight of the secondary component.
   logic [2*QW-1:0]              vs_prod;
   logic [QW-1:0]                f_frac;
   logic [QW-1:0]                saw_dist;
   logic [QW-1:0]                chroma2_in, chroma2_ff;
   logic [QW-1:0]                weight_in, weight_ff;
   logic [QW-1:0]                val2_ff;
   hsv2rgb_pkg::sector_type      sector2_in, sector2_ff;

   always_comb begin
      vs_prod    = (2 * QW)'(val_q_ff) * (2 * QW)'(sat_q_ff);
      chroma2_in = vs_prod[hsv2rgb_pkg::QFrac+QW-1:hsv2rgb_pkg::QFrac];
      f_frac     = t_ff[QW-1:0];
      if (f_frac >= QW'(hsv2rgb_pkg::QOne))
         saw_dist = f_frac - QW'(hsv2rgb_pkg::QOne);
      else
         saw_dist = QW'(hsv2rgb_pkg::QOne) - f_frac;
      weight_in  = QW'(hsv2rgb_pkg::QOne) - saw_dist;
      sector2_in = hsv2rgb_pkg::sector_type'(t_ff[TW-1:hsv2rgb_pkg::QFrac]);
   end

   always_ff @(posedge clock) begin
      if (load2) begin
         chroma2_ff <= chroma2_in;
         weight_ff  <= weight_in;
         val2_ff    <= val_q_ff;
         sector2_ff <= sector2_in;
      end
   end

   // Stage 3: secondary component and the offset added to every channel.
   logic [2*QW-1:0]              cw_prod;
   logic [QW-1:0]                second_in, second_ff;
   logic [QW-1:0]                offset_in, offset_ff;
   logic [QW-1:0]                chroma3_ff;
   hsv2rgb_pkg::sector_type      sector3_ff;

   always_comb begin
      cw_prod   = (2 * QW)'(chroma2_ff) * (2 * QW)'(weight_ff);
      second_in = cw_prod[hsv2rgb_pkg::QFrac+QW-1:hsv2rgb_pkg::QFrac];
      offset_in = val2_ff - chroma2_ff;
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         second_ff  <= second_in;
         offset_ff  <= offset_in;
         chroma3_ff <= chroma2_ff;
         sector3_ff <= sector2_ff;
      end
   end

   // Stage 4: route chroma and secondary by sector, add offset, scale to 8 bits.
   logic [QW-1:0]                red_q, green_q, blue_q;
   logic [CW-1:0]                red_in, green_in, blue_in;
   logic [CW-1:0]                red_ff, green_ff, blue_ff;

   always_comb begin
      case (sector3_ff)
         hsv2rgb_pkg::SEC_RED_YELLOW: begin
            red_q = chroma3_ff; green_q = second_ff;  blue_q = '0;
         end
         hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
            red_q = second_ff;  green_q = chroma3_ff; blue_q = '0;
         end
         hsv2rgb_pkg::SEC_GREEN_CYAN: begin
            red_q = '0;         green_q = chroma3_ff; blue_q = second_ff;
         end
         hsv2rgb_pkg::SEC_CYAN_BLUE: begin
            red_q = '0;         green_q = second_ff;  blue_q = chroma3_ff;
         end
         hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
            red_q = second_ff;  green_q = '0;         blue_q = chroma3_ff;
         end
         default: begin
            red_q = chroma3_ff; green_q = '0;         blue_q = second_ff;
         end
      endcase
      red_in   = to_chan(red_q + offset_ff);
      green_in = to_chan(green_q + offset_ff);
      blue_in  = to_chan(blue_q + offset_ff);
   end

   always_ff @(posedge clock) begin
      if (load4) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_chan.valid = valid4_ff;
   assign rsp_chan.red   = red_ff;
   assign rsp_chan.green = green_ff;
   assign rsp_chan.blue  = blue_ff;

   // The hue position never reaches six sectors.
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      valid1_ff |-> (t_ff < TW'(6 * hsv2rgb_pkg::QOne)))
      else $error("hue position out of range in stage 1");

   // The secondary component never exceeds the chroma.
   a_second_le_chroma: assert property (@(posedge clock) disable iff (reset)
      valid3_ff |-> (second_ff <= chroma3_ff))
      else $error("secondary component above chroma in stage 3");

   // Requests are refused only when every stage is full and the output is stalled.
   a_ready_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (valid1_ff && valid2_ff && valid3_ff && valid4_ff
                           && !rsp_chan.ready))
      else $error("request refused while the pipeline has room");

   // Stage 3, when held, keeps its valid bit.
   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      (valid3_ff && !load3) |=> valid3_ff)
      else $error("stalled stage 3 lost its transaction");

endmodule

FILE: tb/sv/hsv2rgb_check.sv
// Monitor of the HSV request and RGB response channels, with color prediction and comparison.
module hsv2rgb_check
   import hsv2rgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   hsv2rgb_req_if      req_mon,
   hsv2rgb_rsp_if      rsp_mon,
   output int unsigned error_count,
   output int unsigned outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
   } rgb_type;

   rgb_type expected_rgb[$];

   // Scales a Q16 unit-range level to an 8-bit channel, truncating and clamping.
   function automatic logic [ChanWidth-1:0] level_to_chan(input logic [31:0] level);
      logic [63:0] scaled;
      scaled = (64'(level) * 64'(ChanMax)) >> QFrac;
      return (scaled > 64'(ChanMax)) ? ChanWidth'(ChanMax) : scaled[ChanWidth-1:0];
   endfunction

   function automatic rgb_type convert_hsv(input logic [HueWidth-1:0] hue,
                                           input logic                 hue_is_byte,
                                           input logic [ChanWidth-1:0] sat,
                                           input logic [ChanWidth-1:0] val);
      logic [63:0] hue_q;
      logic [31:0] sat_q, val_q, chroma, second, offset, t_q, frac, saw_dist;
      logic [31:0] red_l, green_l, blue_l;
      sector_type  sector;
      rgb_type     rgb;
      if (hue_is_byte)
         hue_q = ((64'(hue[7:0]) * 64'(DegFull)) << QFrac) / 64'(ByteOfMax);
      else
         hue_q = (64'(hue) % 64'(DegFull)) << QFrac;
      // A byte hue of 255 lands on exactly 360 degrees, which is red again.
      if (hue_q >= (64'(DegFull) << QFrac))
         hue_q = hue_q - (64'(DegFull) << QFrac);

      sat_q  = (32'(sat) << QFrac) / 32'(ByteOfMax);
      val_q  = (32'(val) << QFrac) / 32'(ByteOfMax);
      chroma = 32'((64'(val_q) * 64'(sat_q)) >> QFrac);

      t_q      = 32'(hue_q / 64'd60);
      frac     = t_q & 32'h1FFFF;
      saw_dist = (frac >= QOne) ? frac - QOne : QOne - frac;
      second   = 32'((64'(chroma) * 64'(QOne - saw_dist)) >> QFrac);
      offset   = val_q - chroma;

      sector = sector_type'(3'(hue_q / (64'd60 << QFrac)));
      case (sector)
         SEC_RED_YELLOW: begin
            red_l = chroma; green_l = second; blue_l = 0;
         end
         SEC_YELLOW_GREEN: begin
            red_l = second; green_l = chroma; blue_l = 0;
         end
         SEC_GREEN_CYAN: begin
            red_l = 0; green_l = chroma; blue_l = second;
         end
         SEC_CYAN_BLUE: begin
            red_l = 0; green_l = second; blue_l = chroma;
         end
         SEC_BLUE_MAGENTA: begin
            red_l = second; green_l = 0; blue_l = chroma;
         end
         default: begin
            red_l = chroma; green_l = 0; blue_l = second;
         end
      endcase

      rgb.red   = level_to_chan(red_l + offset);
      rgb.green = level_to_chan(green_l + offset);
      rgb.blue  = level_to_chan(blue_l + offset);
      return rgb;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      rgb_type want;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rgb.size() == 0) begin
               report_mismatch($sformatf("unexpected response rgb=%0d/%0d/%0d",
                  rsp_mon.red, rsp_mon.green, rsp_mon.blue));
            end else begin
               want = expected_rgb.pop_front();
               if (rsp_mon.red !== want.red)
                  report_mismatch($sformatf("red got %0d expected %0d",
                     rsp_mon.red, want.red));
               if (rsp_mon.green !== want.green)
                  report_mismatch($sformatf("green got %0d expected %0d",
                     rsp_mon.green, want.green));
               if (rsp_mon.blue !== want.blue)
                  report_mismatch($sformatf("blue got %0d expected %0d",
                     rsp_mon.blue, want.blue));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_rgb.push_back(convert_hsv(req_mon.hue, req_mon.hue_is_byte,
                                               req_mon.saturation, req_mon.value));
      end
      // Updated after the edge, so the stimulus side always reads a settled count.
      outstanding <= expected_rgb.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the HSV to RGB converter testbench: clock, reset, stimulus and verdict.
module tb_top;
   import hsv2rgb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CycleLimit  = 200000;
   localparam int          RandomItems = 700;

   logic        clock;
   logic        reset;
   logic        steady;
   int unsigned error_count;
   int unsigned outstanding;
   int unsigned cycle_count;
   int unsigned stall_left;

   hsv2rgb_req_if req_chan();
   hsv2rgb_rsp_if rsp_chan();

   hsv_to_rgb_converter_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hsv2rgb_check u_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      steady               = 1'b0;
      cycle_count          = 0;
      stall_left           = 0;
      req_chan.valid       = 1'b0;
      req_chan.hue         = '0;
      req_chan.hue_is_byte = 1'b0;
      req_chan.saturation  = '0;
      req_chan.value       = '0;
      rsp_chan.ready       = 1'b0;
   end

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response side: random stalls, none started during the steady stretch.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!steady && $urandom_range(99) < 3) begin
         stall_left = $urandom_range(0, 6);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Called at a clock edge; returns at the edge that accepts the transaction.
   task automatic send_hsv(input logic [HueWidth-1:0]  hue,
                           input logic                 hue_is_byte,
                           input logic [ChanWidth-1:0] sat,
                           input logic [ChanWidth-1:0] val);
      if (!steady && $urandom_range(99) < 4) begin
         req_chan.valid <= 1'b0;
         req_chan.hue   <= HueWidth'($urandom);
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.hue         <= hue;
      req_chan.hue_is_byte <= hue_is_byte;
      req_chan.saturation  <= sat;
      req_chan.value       <= val;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [ChanWidth-1:0] random_level();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return ChanWidth'($urandom);
      endcase
   endfunction

   initial begin
      logic [HueWidth-1:0] hue;
      logic                is_byte;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sector boundaries and wrap of degree hues, mostly at full saturation and value.
      send_hsv(10'd0,    1'b0, 8'd255, 8'd255);
      send_hsv(10'd60,   1'b0, 8'd255, 8'd255);
      send_hsv(10'd120,  1'b0, 8'd255, 8'd255);
      send_hsv(10'd180,  1'b0, 8'd255, 8'd255);
      send_hsv(10'd240,  1'b0, 8'd255, 8'd255);
      send_hsv(10'd300,  1'b0, 8'd255, 8'd255);
      send_hsv(10'd359,  1'b0, 8'd255, 8'd255);
      send_hsv(10'd360,  1'b0, 8'd255, 8'd255);
      send_hsv(10'd719,  1'b0, 8'd200, 8'd180);
      send_hsv(10'd1023, 1'b0, 8'd255, 8'd255);
      send_hsv(10'd30,   1'b0, 8'd128, 8'd77);
      // Byte-scale hues, including the one that wraps to red and the ignored upper bits.
      send_hsv(10'd0,    1'b1, 8'd255, 8'd255);
      send_hsv(10'd255,  1'b1, 8'd255, 8'd255);
      send_hsv(10'd256,  1'b1, 8'd255, 8'd255);
      send_hsv(10'd511,  1'b1, 8'd255, 8'd255);
      send_hsv(10'd1023, 1'b1, 8'd100, 8'd250);
      send_hsv(10'd43,   1'b1, 8'd255, 8'd255);
      send_hsv(10'd128,  1'b1, 8'd170, 8'd90);
      send_hsv(10'd213,  1'b1, 8'd1,   8'd254);
      // Zero saturation gives gray; zero value gives black.
      send_hsv(10'd200,  1'b0, 8'd0,   8'd255);
      send_hsv(10'd77,   1'b1, 8'd0,   8'd123);
      send_hsv(10'd150,  1'b0, 8'd255, 8'd0);
      send_hsv(10'd0,    1'b0, 8'd0,   8'd0);
      send_hsv(10'd1023, 1'b1, 8'd255, 8'd1);
      drain_results();

      for (int n = 0; n < RandomItems; n++) begin
         steady = (n >= 300 && n < 420);
         if (n == 500)
            drain_results();
         is_byte = $urandom_range(2) == 0;
         case ($urandom_range(7))
            0:       hue = is_byte ? HueWidth'($urandom_range(250, 255)) :
                                     HueWidth'(60 * $urandom_range(0, 17));
            1:       hue = is_byte ? HueWidth'($urandom_range(0, 255)) :
                                     HueWidth'($urandom_range(0, 359));
            default: hue = HueWidth'($urandom);
         endcase
         send_hsv(hue, is_byte, random_level(), random_level());
      end
      steady = 1'b0;
      drain_results();
      repeat (10) @(posedge clock);

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_ifs.sv
sv/hsv_to_rgb_converter_top.sv
tb/sv/hsv2rgb_check.sv
tb/sv/tb_top.sv
